/* sv/fdeu_pkg.sv */
// Package for the FDTD Drude E-field cell update unit.
// Holds grid constants, field codes, register indexes and Q8.24 helpers.
// No dependencies.
package fdeu_pkg;

    localparam int GRID_X      = 64;
    localparam int GRID_Y      = 64;
    localparam int STORE_DEPTH = 4096;
    localparam int IDX_W       = 12;
    localparam int CELLS       = GRID_X * GRID_Y;

    localparam logic [1:0] FUNC_INTERIOR = 2'd0;
    localparam logic [1:0] FUNC_ROW      = 2'd1;
    localparam logic [1:0] FUNC_COL      = 2'd2;

    localparam logic [3:0] MAT_DRUDE = 4'd2;
    localparam logic [3:0] MAT_PEC   = 4'd4;

    localparam logic [2:0] REG_FIELD_KEEP = 3'd0;
    localparam logic [2:0] REG_CURL       = 3'd1;
    localparam logic [2:0] REG_CURRENT    = 3'd2;
    localparam logic [2:0] REG_DECAY      = 3'd3;
    localparam logic [2:0] REG_DRIVE      = 3'd4;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // round a Q16.48 product to Q8.24 (half up), then saturate
    function automatic logic signed [31:0] qround(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd8388608) >>> 24;
        return sat64(t);
    endfunction

endpackage

/* sv/fdtd_drude_e_field_cell_update_unit.sv */
// Top level of the FDTD 2D TE Drude E-field cell update unit.
// Eight-stage pipeline with two current stores; uses fdeu_pkg.
//
//  channel | signals                                   | accepted when
//  --------+-------------------------------------------+----------------------
//  input   | in_valid/in_stall, func..mat_curl         | in_valid & !in_stall
//  output  | out_valid/out_stall, ex_new, ey_new       | out_valid & !out_stall
//  config  | cfg_write, cfg_index, cfg_data            | cfg_write
//
// One cell per cycle while in_stall is low; cells pass stages A..H to out_valid.
// After reset both current stores are cleared, one entry per cycle, over all 4096
// entries with in_stall high; config writes are taken during that pass.
// A Drude cell whose index matches a Drude cell still in stages A..G waits
// until that transaction has written its currents back (read-modify-write).
// out_stall with out_valid high freezes the pipeline; nothing is dropped or repeated.
module fdtd_drude_e_field_cell_update_unit
    import fdeu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [2:0]              cfg_index,
    input  logic [31:0]             cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              func,
    input  logic [IDX_W-1:0]        cell_index,
    input  logic [3:0]              material,
    input  logic signed [31:0]      ex_old,
    input  logic signed [31:0]      ey_old,
    input  logic signed [31:0]      hz_here,
    input  logic signed [31:0]      hz_prev_y,
    input  logic signed [31:0]      hz_prev_x,
    input  logic signed [31:0]      grade_y,
    input  logic signed [31:0]      grade_x,
    input  logic signed [31:0]      mat_keep,
    input  logic signed [31:0]      mat_curl,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [31:0]      ex_new,
    output logic signed [31:0]      ey_new
);

    localparam int CLR_W = $clog2(STORE_DEPTH) + 1;

    typedef struct packed {
        logic             valid;
        logic             wr;      // Drude cell inside grid: store read-modify-write
        logic             pec;
        logic             upd_x;
        logic             upd_y;
        logic [IDX_W-1:0] idx;
    } ctl_t;

    // configuration
    logic signed [31:0] c1_reg, c2_reg, c3_reg, kappa_reg, beta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg    <= '0;
            c2_reg    <= '0;
            c3_reg    <= '0;
            kappa_reg <= '0;
            beta_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FIELD_KEEP: c1_reg    <= cfg_data;
                REG_CURL:       c2_reg    <= cfg_data;
                REG_CURRENT:    c3_reg    <= cfg_data;
                REG_DECAY:      kappa_reg <= cfg_data;
                REG_DRIVE:      beta_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // clearing pass
    logic [CLR_W-1:0] clr_cnt_reg;
    logic             clearing;

    assign clearing = (32'(clr_cnt_reg) < STORE_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (clearing)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    // pipeline control
    ctl_t a_ctl_reg, b_ctl_reg, c_ctl_reg, d_ctl_reg, e_ctl_reg, f_ctl_reg, g_ctl_reg;
    logic h_valid_reg;
    logic adv, in_accept, in_wr, hit;

    assign adv = !h_valid_reg || !out_stall;

    assign in_wr = (func == FUNC_INTERIOR) && (material == MAT_DRUDE)
                   && (32'(cell_index) < CELLS);

    function automatic logic match(input ctl_t c, input logic [IDX_W-1:0] i);
        return c.valid && c.wr && (c.idx == i);
    endfunction

    assign hit = match(a_ctl_reg, cell_index) || match(b_ctl_reg, cell_index)
              || match(c_ctl_reg, cell_index) || match(d_ctl_reg, cell_index)
              || match(e_ctl_reg, cell_index) || match(f_ctl_reg, cell_index)
              || match(g_ctl_reg, cell_index);

    assign in_stall  = clearing || !adv || (in_wr && hit);
    assign in_accept = in_valid && !in_stall;

    // input decode
    ctl_t               in_ctl;
    logic               in_drude;
    logic signed [31:0] in_dy, in_dx;

    always_comb
    begin
        in_drude     = (func == FUNC_INTERIOR) && (material == MAT_DRUDE);
        in_ctl.valid = in_accept;
        in_ctl.wr    = in_wr;
        in_ctl.pec   = (func == FUNC_INTERIOR) && (material == MAT_PEC);
        in_ctl.upd_x = (func == FUNC_INTERIOR) || (func == FUNC_ROW);
        in_ctl.upd_y = (func == FUNC_INTERIOR) || (func == FUNC_COL);
        in_ctl.idx   = cell_index;
        in_dy        = sat64(64'(hz_here) - 64'(hz_prev_y));
        in_dx        = sat64(64'(hz_here) - 64'(hz_prev_x));
    end

    // current stores
    logic signed [31:0] jx_mem [STORE_DEPTH];
    logic signed [31:0] jy_mem [STORE_DEPTH];
    logic signed [31:0] jx_rd_reg, jy_rd_reg;
    logic               mem_we, pipe_we;
    logic [IDX_W-1:0]   mem_addr;
    logic signed [31:0] mem_wx, mem_wy, jnew_x, jnew_y;

    // stage registers
    logic signed [31:0] a_ex_reg, a_ey_reg, a_gy_reg, a_gx_reg, a_keep_reg, a_curl_reg;
    logic signed [31:0] a_dy_reg, a_dx_reg;
    logic signed [63:0] b_pk_x_reg, b_pk_y_reg, b_pc_x_reg, b_pc_y_reg;
    logic signed [63:0] b_pj_x_reg, b_pj_y_reg, b_pd_x_reg, b_pd_y_reg;
    logic signed [31:0] b_ex_reg, b_ey_reg, b_gy_reg, b_gx_reg;
    logic signed [31:0] c_k_x_reg, c_k_y_reg, c_c_x_reg, c_c_y_reg;
    logic signed [31:0] c_jc_x_reg, c_jc_y_reg, c_dk_x_reg, c_dk_y_reg;
    logic signed [31:0] c_ex_reg, c_ey_reg, c_gy_reg, c_gx_reg;
    logic signed [63:0] d_pg_x_reg, d_pg_y_reg;
    logic signed [31:0] d_k_x_reg, d_k_y_reg, d_jc_x_reg, d_jc_y_reg;
    logic signed [31:0] d_dk_x_reg, d_dk_y_reg, d_ex_reg, d_ey_reg;
    logic signed [31:0] e_en_x_reg, e_en_y_reg, e_dk_x_reg, e_dk_y_reg, e_ex_reg, e_ey_reg;
    logic signed [31:0] f_s_x_reg, f_s_y_reg, f_fx_reg, f_fy_reg, f_dk_x_reg, f_dk_y_reg;
    logic signed [63:0] g_pb_x_reg, g_pb_y_reg;
    logic signed [31:0] g_fx_reg, g_fy_reg, g_dk_x_reg, g_dk_y_reg;
    logic signed [31:0] ex_new_reg, ey_new_reg;
    logic signed [31:0] a_jx, a_jy;

    assign jnew_x  = sat64(64'(g_dk_x_reg) + 64'(qround(g_pb_x_reg)));
    assign jnew_y  = sat64(64'(g_dk_y_reg) + 64'(qround(g_pb_y_reg)));
    assign pipe_we = adv && g_ctl_reg.valid && g_ctl_reg.wr;
    assign mem_we  = clearing || pipe_we;
    assign mem_addr = clearing ? clr_cnt_reg[IDX_W-1:0] : g_ctl_reg.idx;
    assign mem_wx  = clearing ? '0 : jnew_x;
    assign mem_wy  = clearing ? '0 : jnew_y;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            jx_mem[mem_addr] <= mem_wx;
            jy_mem[mem_addr] <= mem_wy;
        end
        if (in_accept)
        begin
            jx_rd_reg <= jx_mem[cell_index];
            jy_rd_reg <= jy_mem[cell_index];
        end
    end

    // non-Drude cells see zero current, so one sum serves every material
    assign a_jx = a_ctl_reg.wr ? jx_rd_reg : '0;
    assign a_jy = a_ctl_reg.wr ? jy_rd_reg : '0;

    // control valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg   <= '0;
            b_ctl_reg   <= '0;
            c_ctl_reg   <= '0;
            d_ctl_reg   <= '0;
            e_ctl_reg   <= '0;
            f_ctl_reg   <= '0;
            g_ctl_reg   <= '0;
            h_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_ctl_reg   <= in_ctl;
            b_ctl_reg   <= a_ctl_reg;
            c_ctl_reg   <= b_ctl_reg;
            d_ctl_reg   <= c_ctl_reg;
            e_ctl_reg   <= d_ctl_reg;
            f_ctl_reg   <= e_ctl_reg;
            g_ctl_reg   <= f_ctl_reg;
            h_valid_reg <= g_ctl_reg.valid;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // A: capture, curl differences, coefficient select
            a_ex_reg   <= ex_old;
            a_ey_reg   <= ey_old;
            a_gy_reg   <= grade_y;
            a_gx_reg   <= grade_x;
            a_keep_reg <= in_drude ? c1_reg : mat_keep;
            a_curl_reg <= in_drude ? c2_reg : mat_curl;
            a_dy_reg   <= in_dy;
            a_dx_reg   <= in_dx;
            // B: first products
            b_pk_x_reg <= 64'(a_keep_reg) * 64'(a_ex_reg);
            b_pk_y_reg <= 64'(a_keep_reg) * 64'(a_ey_reg);
            b_pc_x_reg <= 64'(a_curl_reg) * 64'(a_dy_reg);
            b_pc_y_reg <= 64'(a_curl_reg) * 64'(a_dx_reg);
            b_pj_x_reg <= 64'(c3_reg) * 64'(a_jx);
            b_pj_y_reg <= 64'(c3_reg) * 64'(a_jy);
            b_pd_x_reg <= 64'(kappa_reg) * 64'(a_jx);
            b_pd_y_reg <= 64'(kappa_reg) * 64'(a_jy);
            b_ex_reg   <= a_ex_reg;
            b_ey_reg   <= a_ey_reg;
            b_gy_reg   <= a_gy_reg;
            b_gx_reg   <= a_gx_reg;
            // C: round
            c_k_x_reg  <= qround(b_pk_x_reg);
            c_k_y_reg  <= qround(b_pk_y_reg);
            c_c_x_reg  <= qround(b_pc_x_reg);
            c_c_y_reg  <= qround(b_pc_y_reg);
            c_jc_x_reg <= qround(b_pj_x_reg);
            c_jc_y_reg <= qround(b_pj_y_reg);
            c_dk_x_reg <= qround(b_pd_x_reg);
            c_dk_y_reg <= qround(b_pd_y_reg);
            c_ex_reg   <= b_ex_reg;
            c_ey_reg   <= b_ey_reg;
            c_gy_reg   <= b_gy_reg;
            c_gx_reg   <= b_gx_reg;
            // D: grading product
            d_pg_x_reg <= 64'(c_c_x_reg) * 64'(c_gy_reg);
            d_pg_y_reg <= 64'(c_c_y_reg) * 64'(c_gx_reg);
            d_k_x_reg  <= c_k_x_reg;
            d_k_y_reg  <= c_k_y_reg;
            d_jc_x_reg <= c_jc_x_reg;
            d_jc_y_reg <= c_jc_y_reg;
            d_dk_x_reg <= c_dk_x_reg;
            d_dk_y_reg <= c_dk_y_reg;
            d_ex_reg   <= c_ex_reg;
            d_ey_reg   <= c_ey_reg;
            // E: field sums, curl added for Ex and subtracted for Ey
            e_en_x_reg <= sat64(64'(d_k_x_reg) + 64'(qround(d_pg_x_reg)) - 64'(d_jc_x_reg));
            e_en_y_reg <= sat64(64'(d_k_y_reg) - 64'(qround(d_pg_y_reg)) - 64'(d_jc_y_reg));
            e_dk_x_reg <= d_dk_x_reg;
            e_dk_y_reg <= d_dk_y_reg;
            e_ex_reg   <= d_ex_reg;
            e_ey_reg   <= d_ey_reg;
            // F: drive sum and result select
            f_s_x_reg  <= sat64(64'(e_en_x_reg) + 64'(e_ex_reg));
            f_s_y_reg  <= sat64(64'(e_en_y_reg) + 64'(e_ey_reg));
            f_fx_reg   <= e_ctl_reg.pec ? '0 : (e_ctl_reg.upd_x ? e_en_x_reg : e_ex_reg);
            f_fy_reg   <= e_ctl_reg.pec ? '0 : (e_ctl_reg.upd_y ? e_en_y_reg : e_ey_reg);
            f_dk_x_reg <= e_dk_x_reg;
            f_dk_y_reg <= e_dk_y_reg;
            // G: drive product; current written back on leaving G
            g_pb_x_reg <= 64'(beta_reg) * 64'(f_s_x_reg);
            g_pb_y_reg <= 64'(beta_reg) * 64'(f_s_y_reg);
            g_fx_reg   <= f_fx_reg;
            g_fy_reg   <= f_fy_reg;
            g_dk_x_reg <= f_dk_x_reg;
            g_dk_y_reg <= f_dk_y_reg;
            // H: output register
            ex_new_reg <= g_fx_reg;
            ey_new_reg <= g_fy_reg;
        end
    end

    assign out_valid = h_valid_reg;
    assign ex_new    = ex_new_reg;
    assign ey_new    = ey_new_reg;

    // checks
    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_accept)
        else $error("transaction accepted during store clearing");

    a_write_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_we |-> adv)
        else $error("store written while pipeline frozen");

    a_no_raw_hazard: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_wr) |-> !match(g_ctl_reg, cell_index))
        else $error("current read overlaps pending write-back");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(g_ctl_reg.valid))
        else $error("output transaction without source");

endmodule
